### rtl/rfae_pkg.sv
// Shared definitions for the rectangle fill address engine.
// Holds field widths, status and register codes, and the item structs.
// Used by every module under rtl.
`default_nettype none

package rfae_pkg;

	localparam int SW_W   = 13;
	localparam int SH_W   = 13;
	localparam int STR_W  = 14;
	localparam int X_W    = 12;
	localparam int Y_W    = 12;
	localparam int RW_W   = 13;
	localparam int RH_W   = 13;
	localparam int PIX_W  = 32;
	localparam int IDX_W  = 25;
	localparam int STAT_W = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_STRIDE = 8192;

	localparam logic [SW_W-1:0]  RST_SCREEN_WIDTH  = SW_W'(1024);
	localparam logic [SH_W-1:0]  RST_SCREEN_HEIGHT = SH_W'(768);
	localparam logic [STR_W-1:0] RST_LINE_STRIDE   = STR_W'(1024);

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 2'd2;

	localparam logic [STAT_W-1:0] ST_IDLE     = 3'd0;
	localparam logic [STAT_W-1:0] ST_WRITE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_DROPPED  = 3'd2;
	localparam logic [STAT_W-1:0] ST_ACCEPTED = 3'd3;
	localparam logic [STAT_W-1:0] ST_REFUSED  = 3'd4;

	typedef struct packed {
		logic              cmd;
		logic              full_screen;
		logic [X_W-1:0]    rect_x;
		logic [Y_W-1:0]    rect_y;
		logic [RW_W-1:0]   rect_w;
		logic [RH_W-1:0]   rect_h;
		logic [PIX_W-1:0]  fill_pixel;
	} rfae_item_t;

	typedef struct packed {
		logic [SW_W-1:0]  screen_width;
		logic [SH_W-1:0]  screen_height;
		logic [STR_W-1:0] line_stride;
	} rfae_cfg_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  write_index;
		logic [PIX_W-1:0]  write_data;
		logic              last;
	} rfae_result_t;

endpackage

`default_nettype wire

### rtl/rfae_cfg_regs.sv
// Configuration registers of the fill engine, limited to the screen maxima.
// Depends on rfae_pkg.
`default_nettype none

module rfae_cfg_regs
	import rfae_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_STRIDE = DEF_MAX_STRIDE
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output rfae_cfg_t                  cfg
);

	logic [SW_W-1:0]  screen_width_q;
	logic [SH_W-1:0]  screen_height_q;
	logic [STR_W-1:0] line_stride_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			line_stride_q   <= RST_LINE_STRIDE;
		end else if (cfg_valid) begin
			if (cfg_index == REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_data[SW_W-1:0];
			end
			if (cfg_index == REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data[SH_W-1:0];
			end
			if (cfg_index == REG_LINE_STRIDE) begin
				line_stride_q <= cfg_data[STR_W-1:0];
			end
		end
	end

	always_comb begin
		cfg.screen_width  = (int'(screen_width_q) > MAX_WIDTH) ?
			SW_W'(MAX_WIDTH) : screen_width_q;
		cfg.screen_height = (int'(screen_height_q) > MAX_HEIGHT) ?
			SH_W'(MAX_HEIGHT) : screen_height_q;
		cfg.line_stride   = (int'(line_stride_q) > MAX_STRIDE) ?
			STR_W'(MAX_STRIDE) : line_stride_q;
	end

endmodule

`default_nettype wire

### rtl/rfae_in_stage.sv
// Input register of the fill engine: holds one accepted item for the core.
// Depends on rfae_pkg.
`default_nettype none

module rfae_in_stage
	import rfae_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire rfae_item_t in_item,
	input  wire logic       take,
	output logic            valid_s1,
	output rfae_item_t      item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

### rtl/rfae_core.sv
// Fill state, clipping and address generation, with the result register.
// Depends on rfae_pkg.
`default_nettype none

module rfae_core
	import rfae_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rfae_cfg_t  cfg,
	input  wire logic       valid_s1,
	input  wire rfae_item_t item_s1,
	output logic            take,
	output logic            valid_s2,
	input  wire logic       out_ready,
	output rfae_result_t    res_s2
);

	logic              busy_q;
	logic [SW_W-1:0]   cur_col_q;
	logic [SH_W-1:0]   cur_row_q;
	logic [X_W-1:0]    first_col_q;
	logic [SW_W-1:0]   end_col_q;
	logic [SH_W-1:0]   end_row_q;
	logic [IDX_W-1:0]  row_base_q;
	logic [PIX_W-1:0]  held_pixel_q;

	logic [X_W-1:0]    x_eff;
	logic [Y_W-1:0]    y_eff;
	logic [RW_W-1:0]   w_eff;
	logic [RH_W-1:0]   h_eff;
	logic [RW_W-1:0]   w_clip;
	logic [RH_W-1:0]   h_clip;
	logic [SW_W-1:0]   end_col_new;
	logic [SH_W-1:0]   end_row_new;
	logic [IDX_W-1:0]  base_prod;
	logic              drop;
	logic [SW_W:0]     col_inc;
	logic [SH_W:0]     row_inc;
	logic              wrap;
	logic              done;
	logic              fire;
	logic              do_start;
	logic              do_tick;
	rfae_result_t      res_d;

	assign take     = !valid_s2 || out_ready;
	assign fire     = take && valid_s1;
	assign do_start = fire && item_s1.cmd && !busy_q && !drop;
	assign do_tick  = fire && !item_s1.cmd && busy_q;

	always_comb begin
		x_eff = item_s1.full_screen ? '0 : item_s1.rect_x;
		y_eff = item_s1.full_screen ? '0 : item_s1.rect_y;
		w_eff = item_s1.full_screen ? RW_W'(cfg.screen_width) : item_s1.rect_w;
		h_eff = item_s1.full_screen ? RH_W'(cfg.screen_height) : item_s1.rect_h;
		drop  = !item_s1.full_screen &&
			((SW_W'(item_s1.rect_x) >= cfg.screen_width) ||
			 (SH_W'(item_s1.rect_y) >= cfg.screen_height));
		w_clip = ((14'(x_eff) + 14'(w_eff)) >= 14'(cfg.screen_width)) ?
			RW_W'(cfg.screen_width - SW_W'(x_eff)) : w_eff;
		h_clip = ((14'(y_eff) + 14'(h_eff)) >= 14'(cfg.screen_height)) ?
			RH_W'(cfg.screen_height - SH_W'(y_eff)) : h_eff;
		end_col_new = SW_W'(x_eff) + SW_W'(w_clip);
		end_row_new = SH_W'(y_eff) + SH_W'(h_clip);
		base_prod   = IDX_W'(y_eff) * IDX_W'(cfg.line_stride);

		col_inc = {1'b0, cur_col_q} + 1'b1;
		row_inc = {1'b0, cur_row_q} + 1'b1;
		wrap    = col_inc >= {1'b0, end_col_q};
		done    = wrap && (row_inc >= {1'b0, end_row_q});

		res_d = '0;
		if (item_s1.cmd) begin
			if (busy_q) begin
				res_d.status = ST_REFUSED;
			end else if (drop) begin
				res_d.status = ST_DROPPED;
			end else begin
				res_d.status = ST_ACCEPTED;
			end
		end else if (busy_q) begin
			res_d.status      = ST_WRITE;
			res_d.write_index = row_base_q + IDX_W'(cur_col_q);
			res_d.write_data  = held_pixel_q;
			res_d.last        = done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			first_col_q  <= '0;
			end_col_q    <= '0;
			end_row_q    <= '0;
			row_base_q   <= '0;
			held_pixel_q <= '0;
		end else if (do_start) begin
			busy_q       <= (w_clip != '0) && (h_clip != '0);
			cur_col_q    <= SW_W'(x_eff);
			cur_row_q    <= SH_W'(y_eff);
			first_col_q  <= x_eff;
			end_col_q    <= end_col_new;
			end_row_q    <= end_row_new;
			row_base_q   <= base_prod;
			held_pixel_q <= item_s1.fill_pixel;
		end else if (do_tick) begin
			if (wrap) begin
				cur_col_q  <= SW_W'(first_col_q);
				cur_row_q  <= row_inc[SH_W-1:0];
				row_base_q <= row_base_q + IDX_W'(cfg.line_stride);
				if (done) begin
					busy_q <= 1'b0;
				end
			end else begin
				cur_col_q <= col_inc[SW_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_d;
		end
	end

endmodule

`default_nettype wire

### rtl/rect_fill_address_engine_top.sv
// Rectangle fill address engine, top level.
// Each item passes the input register, then the result register; m_tready can stall both.
// Throughput: one item per cycle while m_tready does not stall, set by that register pair.
// Reset: arst_n clears the fill state and loads the default screen registers.
// Depends on rfae_pkg, rfae_cfg_regs, rfae_in_stage and rfae_core.
`default_nettype none

module rect_fill_address_engine_top
	import rfae_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_STRIDE = DEF_MAX_STRIDE
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// rect_x, rect_y, rect_w, rect_h, fill_pixel, zero fill
	input  wire logic [87:0]           s_tdata,
	// cmd, full_screen
	input  wire logic [1:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// write_index, write_data, zero fill
	output logic [63:0]                m_tdata,
	// status
	output logic [STAT_W-1:0]          m_tuser,
	output logic                       m_tlast,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	rfae_cfg_t    cfg;
	rfae_item_t   in_item;
	rfae_item_t   item_s1;
	rfae_result_t res_s2;
	logic         valid_s1;
	logic         take;

	always_comb begin
		in_item.cmd         = s_tuser[0];
		in_item.full_screen = s_tuser[1];
		in_item.rect_x      = s_tdata[11:0];
		in_item.rect_y      = s_tdata[23:12];
		in_item.rect_w      = s_tdata[36:24];
		in_item.rect_h      = s_tdata[49:37];
		in_item.fill_pixel  = s_tdata[81:50];
	end

	rfae_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_STRIDE (MAX_STRIDE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rfae_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rfae_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.take      (take),
		.valid_s2  (m_tvalid),
		.out_ready (m_tready),
		.res_s2    (res_s2)
	);

	assign m_tdata = {7'b0, res_s2.write_data, res_s2.write_index};
	assign m_tuser = res_s2.status;
	assign m_tlast = res_s2.last;

endmodule

`default_nettype wire
